@@ hw/rtl/tpsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsq_pkg
// Shared commands, states and records of the three-class send queue.
// ----------------------------------------------------------------------------
package tpsq_pkg;

    typedef enum logic [2:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_PEEK    = 3'd1,
        CMD_COMMIT  = 3'd2,
        CMD_DEFER   = 3'd3,
        CMD_PURGE   = 3'd4,
        CMD_CLEAR   = 3'd5,
        CMD_QUERY   = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    localparam int NUM_CLASSES = 3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  cls;
        logic [15:0] handle;
        logic [15:0] key;
        logic [31:0] tval;
    } req_t;

    typedef struct packed {
        logic        pending_valid;
        logic [1:0]  pending_priority;
        logic [15:0] pending_handle;
        logic [15:0] pending_key;
        logic [5:0]  total_count;
        logic        deadline_valid;
        logic [31:0] deadline;
        logic        key_present;
        logic        overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_CHECK,
        ST_NEXT,
        ST_OUT
    } state_t;

endpackage

@@ hw/rtl/tpsq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsq_front
// Accepts command beats, maps the class code and holds them in a two-entry
// queue for the engine.
// ----------------------------------------------------------------------------
module tpsq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpsq_pkg::req_t    in_req,
    output logic              q_valid,
    input  logic              q_ready,
    output tpsq_pkg::req_t    q_req
);
    tpsq_pkg::req_t buf_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    tpsq_pkg::req_t mapped;
    logic push, pop;

    always_comb begin
        mapped = in_req;
        if (in_req.cls == 2'd3) begin
            mapped.cls = 2'd2;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= mapped;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ hw/rtl/tpsq_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsq_engine
// Executes commands on the three descriptor memories. Purge walks each class
// and query to a match, one entry per step; an output register holds results.
// ----------------------------------------------------------------------------
module tpsq_engine #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  tpsq_pkg::req_t    q_req,
    output logic              r_valid,
    input  logic              r_ready,
    output tpsq_pkg::rsp_t    r_rsp
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (CW + 2 > 6) ? CW + 2 : 6;

    logic [31:0] mem0 [QUEUE_DEPTH];
    logic [31:0] mem1 [QUEUE_DEPTH];
    logic [31:0] mem2 [QUEUE_DEPTH];

    logic [AW-1:0] head_reg [3];
    logic [AW-1:0] head_next [3];
    logic [CW-1:0] count_reg [3];
    logic [CW-1:0] count_next [3];
    logic [31:0]   retry_reg, retry_next;

    tpsq_pkg::state_t state_reg, state_next;
    tpsq_pkg::req_t   req_reg, req_next;
    logic [1:0]       cls_reg, cls_next;
    logic [CW-1:0]    idx_reg, idx_next, kept_reg, kept_next;
    logic             found_reg, found_next;
    logic [31:0]      rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    tpsq_pkg::rsp_t   out_reg, out_next;

    logic          rd_en;
    logic [1:0]    rd_cls;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [1:0]    wr_cls;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [CW-1:0] sel_count;
    logic [AW-1:0] sel_head;
    logic [1:0]    peek_cls;
    logic          peek_any;
    logic [TW-1:0] total;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, h} + {1'b0, o};
        if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            unique case (wr_cls)
                2'd0:    mem0[wr_addr] <= wr_data;
                2'd1:    mem1[wr_addr] <= wr_data;
                default: mem2[wr_addr] <= wr_data;
            endcase
        end
        if (rd_en) begin
            unique case (rd_cls)
                2'd0:    rd_data_reg <= mem0[rd_addr];
                2'd1:    rd_data_reg <= mem1[rd_addr];
                default: rd_data_reg <= mem2[rd_addr];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg     <= tpsq_pkg::ST_IDLE;
            retry_reg     <= '0;
            out_valid_reg <= 1'b0;
            cls_reg       <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            retry_reg     <= retry_next;
            out_valid_reg <= out_valid_next;
            cls_reg       <= cls_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    assign sel_count = count_reg[cls_reg];
    assign sel_head  = head_reg[cls_reg];
    assign total = TW'(count_reg[0]) + TW'(count_reg[1]) + TW'(count_reg[2]);
    assign peek_any = (count_reg[0] != '0) || (count_reg[1] != '0) || (count_reg[2] != '0);
    assign peek_cls = (count_reg[0] != '0) ? 2'd0 : ((count_reg[1] != '0) ? 2'd1 : 2'd2);

    assign r_valid = out_valid_reg;
    assign r_rsp   = out_reg;

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        cls_next       = cls_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        retry_next     = retry_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_ready        = 1'b0;
        rd_en          = 1'b0;
        rd_cls         = cls_reg;
        rd_addr        = wrap(sel_head, idx_reg);
        wr_en          = 1'b0;
        wr_cls         = cls_reg;
        wr_addr        = wrap(sel_head, kept_reg);
        wr_data        = rd_data_reg;
        for (int i = 0; i < 3; i++) begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
        end
        if (out_valid_reg && r_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tpsq_pkg::ST_IDLE: begin
                q_ready = !out_valid_reg || r_ready;
                if (q_valid && q_ready) begin
                    req_next   = q_req;
                    cls_next   = 2'd0;
                    idx_next   = '0;
                    kept_next  = '0;
                    found_next = 1'b0;
                    out_next   = '0;
                    unique case (tpsq_pkg::cmd_t'(q_req.cmd))
                        tpsq_pkg::CMD_ENQUEUE: begin
                            if (count_reg[q_req.cls] == CW'(QUEUE_DEPTH)) begin
                                out_next.overflow = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_cls  = q_req.cls;
                                wr_addr = wrap(head_reg[q_req.cls], count_reg[q_req.cls]);
                                wr_data = {q_req.handle, q_req.key};
                                count_next[q_req.cls] = count_reg[q_req.cls] + CW'(1);
                            end
                            state_next = tpsq_pkg::ST_OUT;
                        end
                        tpsq_pkg::CMD_PEEK: begin
                            if (q_req.tval >= retry_reg && peek_any) begin
                                cls_next   = peek_cls;
                                found_next = 1'b1;
                                rd_en      = 1'b1;
                                rd_cls     = peek_cls;
                                rd_addr    = head_reg[peek_cls];
                                state_next = tpsq_pkg::ST_WAIT;
                            end else begin
                                state_next = tpsq_pkg::ST_OUT;
                            end
                        end
                        tpsq_pkg::CMD_COMMIT: begin
                            if (count_reg[q_req.cls] != '0) begin
                                head_next[q_req.cls]  = wrap(head_reg[q_req.cls], CW'(1));
                                count_next[q_req.cls] = count_reg[q_req.cls] - CW'(1);
                            end
                            retry_next = '0;
                            state_next = tpsq_pkg::ST_OUT;
                        end
                        tpsq_pkg::CMD_DEFER: begin
                            retry_next = q_req.tval;
                            state_next = tpsq_pkg::ST_OUT;
                        end
                        tpsq_pkg::CMD_PURGE, tpsq_pkg::CMD_QUERY: begin
                            state_next = tpsq_pkg::ST_RD;
                        end
                        tpsq_pkg::CMD_CLEAR: begin
                            for (int i = 0; i < 3; i++) begin
                                head_next[i]  = '0;
                                count_next[i] = '0;
                            end
                            retry_next = '0;
                            state_next = tpsq_pkg::ST_OUT;
                        end
                        default: state_next = tpsq_pkg::ST_OUT;
                    endcase
                end
            end
            tpsq_pkg::ST_RD: begin
                if (idx_reg == sel_count || found_reg) begin
                    state_next = tpsq_pkg::ST_NEXT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = tpsq_pkg::ST_CHECK;
                end
            end
            tpsq_pkg::ST_CHECK: begin
                if (rd_data_reg[15:0] == req_reg.key) begin
                    if (req_reg.cmd == tpsq_pkg::CMD_QUERY) found_next = 1'b1;
                end else if (req_reg.cmd == tpsq_pkg::CMD_PURGE) begin
                    wr_en     = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = tpsq_pkg::ST_RD;
            end
            tpsq_pkg::ST_NEXT: begin
                if (req_reg.cmd == tpsq_pkg::CMD_PURGE) count_next[cls_reg] = kept_reg;
                idx_next  = '0;
                kept_next = '0;
                if (cls_reg == 2'd2 || found_reg) begin
                    state_next = tpsq_pkg::ST_OUT;
                end else begin
                    cls_next   = cls_reg + 2'd1;
                    state_next = tpsq_pkg::ST_RD;
                end
            end
            tpsq_pkg::ST_WAIT: begin
                out_next.pending_valid    = 1'b1;
                out_next.pending_priority = cls_reg;
                out_next.pending_handle   = rd_data_reg[31:16];
                out_next.pending_key      = rd_data_reg[15:0];
                state_next = tpsq_pkg::ST_OUT;
            end
            tpsq_pkg::ST_OUT: begin
                if (!out_valid_reg || r_ready) begin
                    out_next.total_count    = total[5:0];
                    out_next.deadline_valid = (total != '0);
                    out_next.deadline       = (total != '0) ? retry_reg : '0;
                    out_next.key_present    = (req_reg.cmd == tpsq_pkg::CMD_QUERY) && found_reg;
                    out_valid_next = 1'b1;
                    state_next     = tpsq_pkg::ST_IDLE;
                end
            end
            default: state_next = tpsq_pkg::ST_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/three_tier_priority_send_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tier_priority_send_queue
// Strict-priority send queue with control, retransmission and new-data classes.
//
// Channel   Dir  Contents
// s_axis    in   command beats (cmd, class, handle, key, tick)
// m_axis    out  one result beat per command
//
// A beat is registered in the two-beat input queue before the engine takes it.
// Enqueue, commit, defer, clear and empty peeks then go to the output state; a
// peek that offers an entry first reads its class memory. Purge and query walk
// the held entries one per step, up to 3*QUEUE_DEPTH of them, class by class.
// Reset is synchronous; the engine takes no new command while a result waits
// unaccepted in the output register, and the input queue accepts until full.
// ----------------------------------------------------------------------------
module three_tier_priority_send_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], handle[18:3], key[34:19], time_value[66:35], zeros
    input  logic [71:0] s_tdata,
    // priority_req[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pending_valid[0], handle[16:1], key[32:17], total_count[38:33],
    // deadline_valid[39], deadline[71:40], key_present[72], overflow[73], zeros
    output logic [79:0] m_tdata,
    // pending_priority[1:0]
    output logic [1:0]  m_tuser
);
    tpsq_pkg::req_t in_req, q_req;
    tpsq_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    always_comb begin
        in_req.cmd    = s_tdata[2:0];
        in_req.handle = s_tdata[18:3];
        in_req.key    = s_tdata[34:19];
        in_req.tval   = s_tdata[66:35];
        in_req.cls    = s_tuser;
    end

    tpsq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    tpsq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_rsp(rsp)
    );

    assign m_tdata = {6'd0, rsp.overflow, rsp.key_present, rsp.deadline,
                      rsp.deadline_valid, rsp.total_count, rsp.pending_key,
                      rsp.pending_handle, rsp.pending_valid};
    assign m_tuser = rsp.pending_priority;

    a_ovf_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[73] |-> !m_tdata[0] && !m_tdata[72])
        else $error("overflow reported with other flags");
    a_dl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[39] |-> m_tdata[71:40] == 32'd0 && !m_tdata[0])
        else $error("deadline or offer while empty");
    a_pv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[39] && m_tuser != 2'd3)
        else $error("bad offer");
endmodule
